// ----- rtl/core/selective_repeat_receive_window_defines.svh -----
// Assertion macros shared by the selective-repeat receive window checkers.
// No dependencies; included by bare file name.
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define SRRW_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srrw assertion failed");

// Next-cycle implication, disabled while rst is high.
`define SRRW_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srrw assertion failed");

`endif

// ----- rtl/core/srrw_pkg.sv -----
// Shared types and constants of the selective-repeat receive window.
// No dependencies.
package srrw_pkg;

   localparam int SEQ_W    = 32;   // sequence number width
   localparam int MAP_W    = 32;   // received map width
   localparam int SACK_W   = 31;   // selective ack bitmap width
   localparam int WIN_W    = 6;    // window register width
   localparam int DIST_W   = 5;    // bit index into the map
   localparam int CSR_AW   = 3;    // byte address width of the register port
   localparam int CSR_DW   = 32;

   localparam logic [WIN_W-1:0] WINDOW_RESET = 6'd8;
   localparam logic             REG_WINDOW   = 1'b0;  // word index of the window register

   // window engine status towards the top level
   typedef struct packed {
      logic idle;   // free to take a segment
      logic done;   // map and expected number settled, waiting to be taken
   } core_stat_type;

endpackage

// ----- rtl/core/srrw_if.sv -----
// Valid/ready channel interfaces for segments in and acknowledgements out.
// Depends on srrw_pkg.
interface srrw_req_if;
   logic                          valid;
   logic                          ready;
   logic [srrw_pkg::SEQ_W-1:0]    segment_seq;
   logic                          short_segment;

   modport source (output valid, segment_seq, short_segment, input ready);
   modport sink   (input valid, segment_seq, short_segment, output ready);
endinterface

interface srrw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [srrw_pkg::SEQ_W-1:0]    ack_next;
   logic [srrw_pkg::SACK_W-1:0]   sack_bits;
   logic                          accepted;
   logic                          finished;

   modport source (output valid, ack_next, sack_bits, accepted, finished, input ready);
   modport sink   (input valid, ack_next, sack_bits, accepted, finished, output ready);
endinterface

// ----- rtl/core/srrw_window_core.sv -----
// Window state and advance sequencer: expected number, received map and the
// one-bit-per-cycle shift/increment unit. Depends on srrw_pkg.
module srrw_window_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [srrw_pkg::SEQ_W-1:0]      seq,
   input  logic [srrw_pkg::WIN_W-1:0]      window,
   input  logic                            take,
   output srrw_pkg::core_stat_type         stat,
   output logic [srrw_pkg::SEQ_W-1:0]      expected,
   output logic [srrw_pkg::MAP_W-1:0]      rx_map,
   output logic                            accepted
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ADV  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [srrw_pkg::SEQ_W-1:0]    expected_ff, expected_in;
   logic [srrw_pkg::MAP_W-1:0]    map_ff, map_in;
   logic                          acc_ff, acc_in;

   logic [srrw_pkg::SEQ_W-1:0]    seq_gap;
   logic                          in_win;

   assign seq_gap = seq - expected_ff;
   assign in_win  = seq_gap < {{(srrw_pkg::SEQ_W-srrw_pkg::WIN_W){1'b0}}, window};

   always_comb begin
      state_in    = state_ff;
      expected_in = expected_ff;
      map_in      = map_ff;
      acc_in      = acc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               acc_in = in_win;
               if (in_win) begin
                  map_in = map_ff | (srrw_pkg::MAP_W'(1) << seq_gap[srrw_pkg::DIST_W-1:0]);
               end
               // only the expected segment opens a run to advance over
               state_in = (in_win && (seq_gap == '0)) ? ST_ADV : ST_FIN;
            end
         end
         ST_ADV: begin
            // bit 0 is set on entry; shift one out per cycle
            map_in      = map_ff >> 1;
            expected_in = expected_ff + srrw_pkg::SEQ_W'(1);
            if (!map_ff[1]) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         expected_ff <= '0;
         map_ff      <= '0;
         acc_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         expected_ff <= expected_in;
         map_ff      <= map_in;
         acc_ff      <= acc_in;
      end
   end

   assign stat.idle = (state_ff == ST_IDLE);
   assign stat.done = (state_ff == ST_FIN);
   assign expected  = expected_ff;
   assign rx_map    = map_ff;
   assign accepted  = acc_ff;

endmodule

// ----- rtl/core/selective_repeat_receive_window.sv -----
// Selective-repeat receive window: takes one segment transfer at a time and
// returns one acknowledgement transfer for each. After acceptance, req is not
// ready again until the expected number has advanced over the run of contiguous
// received segments and the acknowledgement is loaded; the advance unit shifts
// the received map and bumps the expected number by one per cycle. A segment
// that is not the expected one skips the advance. The acknowledgement sits in an
// output register; if it has not been taken when the next one is ready, the
// engine holds until the register frees. Depends on srrw_pkg, srrw_if and
// srrw_window_core.
module selective_repeat_receive_window #(
   parameter int MAX_WINDOW = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   srrw_req_if.sink                        req_chan,
   srrw_rsp_if.source                      rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [srrw_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [srrw_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic [srrw_pkg::CSR_DW-1:0]     csr_prdata,
   output logic                            csr_pready
);

   // window is capped by the parameter and by the map width
   localparam int WIN_CAP_I = (MAX_WINDOW < srrw_pkg::MAP_W) ? MAX_WINDOW : srrw_pkg::MAP_W;
   localparam logic [srrw_pkg::WIN_W-1:0] WIN_CAP = srrw_pkg::WIN_W'(WIN_CAP_I);

   // ---------------- configuration register ----------------
   logic [srrw_pkg::WIN_W-1:0]    window_ff, window_in;
   logic                          csr_wr;
   logic                          csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == srrw_pkg::REG_WINDOW);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      window_in = window_ff;
      if (csr_wr && csr_hit) begin
         window_in = csr_pwdata[srrw_pkg::WIN_W-1:0];
      end
   end

   // reads of unknown offsets return zero
   assign csr_prdata = csr_hit ?
      {{(srrw_pkg::CSR_DW-srrw_pkg::WIN_W){1'b0}}, window_ff} : '0;

   // effective window: zero acts as one, clamp at the cap
   logic [srrw_pkg::WIN_W-1:0]    win_eff;
   always_comb begin
      if (window_ff == '0) begin
         win_eff = srrw_pkg::WIN_W'(1);
      end else if (window_ff > WIN_CAP) begin
         win_eff = WIN_CAP;
      end else begin
         win_eff = window_ff;
      end
   end

   // ---------------- window engine ----------------
   srrw_pkg::core_stat_type       stat;
   logic [srrw_pkg::SEQ_W-1:0]    expected;
   logic [srrw_pkg::MAP_W-1:0]    rx_map;
   logic                          core_acc;
   logic                          req_xfer;
   logic                          take;

   assign req_chan.ready = stat.idle;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   srrw_window_core u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (req_xfer),
      .seq      (req_chan.segment_seq),
      .window   (win_eff),
      .take     (take),
      .stat     (stat),
      .expected (expected),
      .rx_map   (rx_map),
      .accepted (core_acc)
   );

   // finished flag rides alongside the engine
   logic fin_ff, fin_in;
   assign fin_in = req_xfer ? req_chan.short_segment : fin_ff;

   // ---------------- acknowledgement build ----------------
   // sack covers the window-1 numbers after ack_next
   logic [srrw_pkg::DIST_W-1:0]   mask_sh;
   logic [srrw_pkg::MAP_W-1:0]    sack_mask;
   logic [srrw_pkg::SACK_W-1:0]   sack;

   assign mask_sh   = srrw_pkg::DIST_W'(win_eff - srrw_pkg::WIN_W'(1));
   assign sack_mask = (srrw_pkg::MAP_W'(1) << mask_sh) - srrw_pkg::MAP_W'(1);
   assign sack      = rx_map[srrw_pkg::MAP_W-1:1] & sack_mask[srrw_pkg::SACK_W-1:0];

   // ---------------- output register ----------------
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [srrw_pkg::SEQ_W-1:0]    ack_ff, ack_in;
   logic [srrw_pkg::SACK_W-1:0]   sack_ff, sack_in;
   logic                          acc_ff, acc_in;
   logic                          rfin_ff, rfin_in;

   // load when the engine is done and the register is free or draining
   assign take = stat.done && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      ack_in       = ack_ff;
      sack_in      = sack_ff;
      acc_in       = acc_ff;
      rfin_in      = rfin_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (take) begin
         rsp_valid_in = 1'b1;
         ack_in       = expected;
         sack_in      = sack;
         acc_in       = core_acc;
         rfin_in      = fin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= srrw_pkg::WINDOW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      fin_ff  <= fin_in;
      ack_ff  <= ack_in;
      sack_ff <= sack_in;
      acc_ff  <= acc_in;
      rfin_ff <= rfin_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.ack_next  = ack_ff;
   assign rsp_chan.sack_bits = sack_ff;
   assign rsp_chan.accepted  = acc_ff;
   assign rsp_chan.finished  = rfin_ff;

endmodule

// ----- rtl/core/srrw_checker.sv -----
// Port-level checker for the selective-repeat receive window, with its bind.
// Depends on srrw_pkg and selective_repeat_receive_window_defines.svh.
`include "selective_repeat_receive_window_defines.svh"

module srrw_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [srrw_pkg::SEQ_W-1:0]      ack_next,
   input logic [srrw_pkg::SACK_W-1:0]     sack_bits
);

   // a stalled acknowledgement holds its payload
`SRRW_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(ack_next) && $stable(sack_bits))

   // one segment at a time: ready drops after a transfer
`SRRW_ASSERT_NXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)

   // a fresh acknowledgement frees the engine for the next segment
`SRRW_ASSERT_IMP(a_ready_after_ack, clock, reset, $rose(rsp_valid), req_ready)

   // nothing pending straight after reset
`SRRW_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && req_ready)

endmodule

bind selective_repeat_receive_window srrw_checker u_srrw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .ack_next  (rsp_chan.ack_next),
   .sack_bits (rsp_chan.sack_bits)
);
